@@ rtl/gnl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Grid neighbor list package
// Shared widths, codes, the site descriptor and the stencil tables.
// ----------------------------------------------------------------------------
package gnl_pkg;

   localparam int SITE_W            = 16;
   localparam int LINK_W            = 20;
   localparam int COUNT_W           = 4;
   localparam int CODE_W            = 4;
   localparam int MAX_ENTRIES       = 9;
   localparam int MODE_W            = 2;
   localparam int DIM_W             = 9;
   localparam int CSR_ADDR_W        = 2;
   localparam int CSR_DATA_W        = 9;
   localparam int REQ_DATA_W        = 8;
   localparam int RSP_DATA_W        = 56;
   localparam int RSP_USER_W        = 2;
   localparam int QUEUE_DEPTH       = 2;
   localparam int DEF_MAX_LENGTH    = 256;
   localparam int DEF_MAX_THICKNESS = 256;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THICKNESS = 2'd2;

   localparam logic [CODE_W-1:0] CODE_UP_X = 4'd6;
   localparam logic [CODE_W-1:0] CODE_MID_X = 4'd3;

   typedef enum logic [1:0] {
      STENCIL_CHAIN  = 2'd0,
      STENCIL_SQUARE = 2'd1,
      STENCIL_CROSS  = 2'd2
   } stencil_type;

   typedef enum logic [1:0] {
      EDGE_LOW  = 2'd0,
      EDGE_MID  = 2'd1,
      EDGE_HIGH = 2'd2
   } edge_type;

   typedef logic [0:MAX_ENTRIES-1][CODE_W-1:0] code_list_type;

   typedef struct packed {
      logic [SITE_W-1:0]  site;
      logic [SITE_W-1:0]  thickness;
      logic [LINK_W-1:0]  offset;
      stencil_type        stencil;
      edge_type           row_edge;
      edge_type           col_edge;
      logic [COUNT_W-1:0] count;
      logic               done;
      logic               error;
   } site_desc_type;

   // Entry code is (dx+1)*3 + (dy+1); the first entry sits in the top nibble.
   function automatic code_list_type stencil_codes(stencil_type s, edge_type r, edge_type c);
      code_list_type codes;
      codes = '0;
      unique case (s)
         STENCIL_SQUARE: begin
            unique case ({r, c})
               {EDGE_LOW,  EDGE_LOW}:  codes = 36'h457800000;
               {EDGE_LOW,  EDGE_MID}:  codes = 36'h457182000;
               {EDGE_LOW,  EDGE_HIGH}: codes = 36'h451200000;
               {EDGE_MID,  EDGE_LOW}:  codes = 36'h453786000;
               {EDGE_MID,  EDGE_MID}:  codes = 36'h453786120;
               {EDGE_MID,  EDGE_HIGH}: codes = 36'h453120000;
               {EDGE_HIGH, EDGE_LOW}:  codes = 36'h437600000;
               {EDGE_HIGH, EDGE_MID}:  codes = 36'h437610000;
               {EDGE_HIGH, EDGE_HIGH}: codes = 36'h431000000;
               default:                codes = '0;
            endcase
         end
         STENCIL_CROSS: begin
            unique case ({r, c})
               {EDGE_LOW,  EDGE_LOW}:  codes = 36'h457000000;
               {EDGE_LOW,  EDGE_MID}:  codes = 36'h457100000;
               {EDGE_LOW,  EDGE_HIGH}: codes = 36'h451000000;
               {EDGE_MID,  EDGE_LOW}:  codes = 36'h453700000;
               {EDGE_MID,  EDGE_MID}:  codes = 36'h453710000;
               {EDGE_MID,  EDGE_HIGH}: codes = 36'h453100000;
               {EDGE_HIGH, EDGE_LOW}:  codes = 36'h437000000;
               {EDGE_HIGH, EDGE_MID}:  codes = 36'h437100000;
               {EDGE_HIGH, EDGE_HIGH}: codes = 36'h431000000;
               default:                codes = '0;
            endcase
         end
         default: begin
            unique case (c)
               EDGE_LOW:  codes = 36'h470000000;
               EDGE_MID:  codes = 36'h147000000;
               EDGE_HIGH: codes = 36'h140000000;
               default:   codes = '0;
            endcase
         end
      endcase
      return codes;
   endfunction

   function automatic logic [COUNT_W-1:0] entry_count(stencil_type s, edge_type r, edge_type c);
      logic [COUNT_W-1:0] rn;
      logic [COUNT_W-1:0] cn;
      logic [COUNT_W-1:0] n;
      rn = (r == EDGE_MID) ? 4'd3 : 4'd2;
      cn = (c == EDGE_MID) ? 4'd3 : 4'd2;
      unique case (s)
         STENCIL_SQUARE: n = (rn == 4'd3) ? (cn + cn + cn) : (cn + cn);
         STENCIL_CROSS:  n = rn + cn - 4'd1;
         default:        n = cn;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

@@ rtl/grid_neighbor_list_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Grid neighbor list generator
// Walks a chain or a rectangular grid and streams each site's neighbor list.
// ----------------------------------------------------------------------------
// Each request beat yields the neighbor list of the next site in row-major
// construction order, one response beat per entry: two or three entries on a
// chain, three to five on the cross stencil, four to nine on the square
// stencil, and a lone beat for a dimension error. The back end emits one
// entry per cycle into its output register while the response side is ready.
// The front end classifies a site in the cycle it is accepted and can run up
// to two sites ahead through the descriptor queue, so a request is taken
// while earlier lists still drain.
// Configuration must only be written while no list is outstanding.
// ----------------------------------------------------------------------------
module grid_neighbor_list_generator
   import gnl_pkg::*;
#(
   parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
   parameter int MAX_THICKNESS = DEF_MAX_THICKNESS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // Bit 0 restart, bits 7:1 zero.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Bits 15:0 site, 31:16 neighbor, 51:32 link_position, 55:52 neighbor_count.
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tlast,
   // Bit 0 grid_done, bit 1 dimension_error.
   output      logic [RSP_USER_W-1:0] rsp_tuser
);

   logic          push_valid;
   logic          push_ready;
   site_desc_type push_desc;
   logic          pop_valid;
   logic          pop_ready;
   site_desc_type pop_desc;

   gnl_front #(
      .MAX_LENGTH    (MAX_LENGTH),
      .MAX_THICKNESS (MAX_THICKNESS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_restart (req_tdata[0]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_desc   (push_desc)
   );

   gnl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   gnl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = push_ready;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tlast && rsp_tdata == '0 && !rsp_tuser[0])
      else $error("dimension error beat is not a lone zero beat");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |->
         rsp_tdata[55:52] >= 4'd2 && rsp_tdata[55:52] <= 4'd9)
      else $error("neighbor count out of range");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> pop_valid && (rsp_tready || !rsp_tvalid))
      else $error("descriptor retired without an output slot");

endmodule
`default_nettype wire

@@ rtl/gnl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Grid neighbor list front end
// Holds the configuration and the walk cursor, classifies each requested
// site and hands a descriptor of it to the queue.
// ----------------------------------------------------------------------------
module gnl_front
   import gnl_pkg::*;
#(
   parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
   parameter int MAX_THICKNESS = DEF_MAX_THICKNESS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   input  wire logic                  req_restart,
   output      logic                  push_valid,
   input  wire logic                  push_ready,
   output      site_desc_type         push_desc
);

   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int THK_W  = $clog2(MAX_THICKNESS + 1);
   localparam int X_W    = $clog2(MAX_LENGTH);
   localparam int Y_W    = $clog2(MAX_THICKNESS);
   localparam int CMP_LW = (LEN_W > DIM_W) ? LEN_W : DIM_W;
   localparam int CMP_TW = (THK_W > DIM_W) ? THK_W : DIM_W;
   localparam int PROD_W = X_W + THK_W + 1;

   logic [MODE_W-1:0] mode_ff;
   logic [DIM_W-1:0]  length_ff;
   logic [DIM_W-1:0]  thickness_ff;

   logic [X_W-1:0]    cursor_x_ff, cursor_x_in;
   logic [Y_W-1:0]    cursor_y_ff, cursor_y_in;
   logic [LINK_W-1:0] offset_ff, offset_in;

   stencil_type        stencil;
   logic [CMP_LW-1:0]  length_ext;
   logic [CMP_TW-1:0]  thickness_ext;
   logic [LEN_W-1:0]   len;
   logic [THK_W-1:0]   thk_sat;
   logic [THK_W-1:0]   thk;
   logic [X_W-1:0]     cx0, cx;
   logic [Y_W-1:0]     cy0, cy;
   logic [LINK_W-1:0]  off0, off;
   logic               dim_err;
   logic               outside;
   logic               cx_last;
   logic               cy_last;
   edge_type           row_edge;
   edge_type           col_edge;
   logic [PROD_W-1:0]  site_full;
   logic [COUNT_W-1:0] count;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_W'(STENCIL_CHAIN);
         length_ff    <= DIM_W'(2);
         thickness_ff <= DIM_W'(2);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE:      mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_LENGTH:    length_ff    <= csr_wdata[DIM_W-1:0];
            CSR_THICKNESS: thickness_ff <= csr_wdata[DIM_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (mode_ff)
         STENCIL_SQUARE: stencil = STENCIL_SQUARE;
         STENCIL_CROSS:  stencil = STENCIL_CROSS;
         default:        stencil = STENCIL_CHAIN;
      endcase

      length_ext    = CMP_LW'(length_ff);
      thickness_ext = CMP_TW'(thickness_ff);
      len     = (length_ext > CMP_LW'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : LEN_W'(length_ext);
      thk_sat = (thickness_ext > CMP_TW'(MAX_THICKNESS)) ?
                THK_W'(MAX_THICKNESS) : THK_W'(thickness_ext);
      thk     = (stencil == STENCIL_CHAIN) ? THK_W'(1) : thk_sat;

      cx0  = req_restart ? '0 : cursor_x_ff;
      cy0  = req_restart ? '0 : cursor_y_ff;
      off0 = req_restart ? '0 : offset_ff;

      dim_err = (len < LEN_W'(2)) || ((stencil != STENCIL_CHAIN) && (thk < THK_W'(2)));
      outside = (LEN_W'(cx0) >= len) || (THK_W'(cy0) >= thk);
      cx  = outside ? '0 : cx0;
      cy  = outside ? '0 : cy0;
      off = outside ? '0 : off0;

      cx_last = (LEN_W'(cx) + LEN_W'(1)) == len;
      cy_last = (THK_W'(cy) + THK_W'(1)) == thk;

      if (cx == '0) begin
         col_edge = EDGE_LOW;
      end else if (cx_last) begin
         col_edge = EDGE_HIGH;
      end else begin
         col_edge = EDGE_MID;
      end
      if (stencil == STENCIL_CHAIN || cy == '0) begin
         row_edge = EDGE_LOW;
      end else if (cy_last) begin
         row_edge = EDGE_HIGH;
      end else begin
         row_edge = EDGE_MID;
      end

      site_full = PROD_W'(cx) * PROD_W'(thk) + PROD_W'(cy);
      count     = entry_count(stencil, row_edge, col_edge);

      push_desc = '0;
      if (dim_err) begin
         push_desc.error = 1'b1;
      end else begin
         push_desc.site      = SITE_W'(site_full);
         push_desc.thickness = SITE_W'(thk);
         push_desc.offset    = off;
         push_desc.stencil   = stencil;
         push_desc.row_edge  = row_edge;
         push_desc.col_edge  = col_edge;
         push_desc.count     = count;
         push_desc.done      = cx_last && cy_last;
      end
      push_valid = req_valid;
      accept     = req_valid && push_ready;

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      offset_in   = offset_ff;
      if (accept) begin
         if (dim_err) begin
            cursor_x_in = cx0;
            cursor_y_in = cy0;
            offset_in   = off0;
         end else if (cx_last && cy_last) begin
            cursor_x_in = '0;
            cursor_y_in = '0;
            offset_in   = '0;
         end else begin
            offset_in = off + LINK_W'(count);
            if (cx_last) begin
               cursor_x_in = '0;
               cursor_y_in = cy + Y_W'(1);
            end else begin
               cursor_x_in = cx + X_W'(1);
               cursor_y_in = cy;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         offset_ff   <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         offset_ff   <= offset_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/gnl_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Grid neighbor list descriptor queue
// A short first-in first-out buffer of site descriptors between the front
// and back ends.
// ----------------------------------------------------------------------------
module gnl_queue
   import gnl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output      logic          push_ready,
   input  wire site_desc_type push_desc,
   output      logic          pop_valid,
   input  wire logic          pop_ready,
   output      site_desc_type pop_desc
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   site_desc_type     entry_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              push;
   logic              pop;

   always_comb begin
      push_ready = fill_ff != CNT_W'(QUEUE_DEPTH);
      pop_valid  = fill_ff != '0;
      pop_desc   = entry_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      fill_in = fill_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/gnl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Grid neighbor list back end
// Expands the queue head descriptor into one result beat per neighbor entry
// or one error beat, and holds each beat in the output register.
// ----------------------------------------------------------------------------
module gnl_back
   import gnl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output      logic                  pop_ready,
   input  wire site_desc_type         pop_desc,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tlast,
   output      logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [COUNT_W-1:0] beat_ff, beat_in;
   logic               valid_ff, valid_in;
   logic [SITE_W-1:0]  site_ff;
   logic [SITE_W-1:0]  neighbor_ff, neighbor_in;
   logic [LINK_W-1:0]  link_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               last_ff, last_in;
   logic               done_ff;
   logic               error_ff;

   code_list_type      codes;
   logic [CODE_W-1:0]  code;
   logic [CODE_W-1:0]  dy;
   logic               advance;

   always_comb begin
      codes = stencil_codes(pop_desc.stencil, pop_desc.row_edge, pop_desc.col_edge);
      code  = codes[beat_ff];

      neighbor_in = pop_desc.site;
      if (code >= CODE_UP_X) begin
         neighbor_in = neighbor_in + pop_desc.thickness;
         dy          = code - CODE_UP_X;
      end else if (code >= CODE_MID_X) begin
         dy = code - CODE_MID_X;
      end else begin
         neighbor_in = neighbor_in - pop_desc.thickness;
         dy          = code;
      end
      if (dy == CODE_W'(2)) begin
         neighbor_in = neighbor_in + SITE_W'(1);
      end else if (dy == '0) begin
         neighbor_in = neighbor_in - SITE_W'(1);
      end

      last_in   = pop_desc.error || ((beat_ff + COUNT_W'(1)) == pop_desc.count);
      advance   = pop_valid && (!valid_ff || rsp_tready);
      pop_ready = advance && last_in;

      beat_in = beat_ff;
      if (advance) begin
         beat_in = last_in ? '0 : beat_ff + COUNT_W'(1);
      end
      valid_in = advance || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         error_ff <= pop_desc.error;
         if (pop_desc.error) begin
            last_ff     <= 1'b0;
            site_ff     <= '0;
            neighbor_ff <= '0;
            link_ff     <= '0;
            count_ff    <= '0;
            done_ff     <= 1'b0;
         end else begin
            last_ff     <= last_in;
            site_ff     <= pop_desc.site;
            neighbor_ff <= neighbor_in;
            link_ff     <= pop_desc.offset + LINK_W'(beat_ff);
            count_ff    <= pop_desc.count;
            done_ff     <= pop_desc.done;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {count_ff, link_ff, neighbor_ff, site_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {error_ff, done_ff};

endmodule
`default_nettype wire

@@ sim/tb_grid_neighbor_list_generator.sv @@
// ----------------------------------------------------------------------------
// Grid neighbor list generator testbench
// Walks the chain, square and cross stencils over small and large grids.
// Each request beat is scored by a local model of the site walk, and each
// response beat is compared field by field with the oldest expected entry.
// A directed table comes first, then random register settings and random
// request traffic. The request side sends in bursts with gaps, and the
// response side stalls on its own pattern, with long hold-offs.
// ----------------------------------------------------------------------------
module tb_grid_neighbor_list_generator
   import gnl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 420;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   // Each entry holds the entry count in the top nibble, then up to nine
   // codes (dx+1)*3 + (dy+1), first entry next. The index is
   // stencil*9 + row edge*3 + column edge.
   localparam logic [0:26][39:0] NEIGHBOR_ORDER = {
      40'h2470000000, 40'h3147000000, 40'h2140000000,
      40'h2470000000, 40'h3147000000, 40'h2140000000,
      40'h2470000000, 40'h3147000000, 40'h2140000000,
      40'h4457800000, 40'h6457182000, 40'h4451200000,
      40'h6453786000, 40'h9453786120, 40'h6453120000,
      40'h4437600000, 40'h6437610000, 40'h4431000000,
      40'h3457000000, 40'h4457100000, 40'h3451000000,
      40'h4453700000, 40'h5453710000, 40'h4453100000,
      40'h3437000000, 40'h4437100000, 40'h3431000000
   };

   typedef struct packed {
      logic [SITE_W-1:0]  site;
      logic [SITE_W-1:0]  neighbor;
      logic [LINK_W-1:0]  link;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               done;
      logic               dim_error;
   } neighbor_entry_type;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_ADDR_W-1:0]  addr;
      logic [CSR_DATA_W-1:0]  value;
      logic                   restart;
      logic                   typed_error;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;

   logic [MODE_W-1:0] cfg_mode = 2'd0;
   logic [DIM_W-1:0]  cfg_length = 9'd2;
   logic [DIM_W-1:0]  cfg_thickness = 9'd2;
   int                cur_x = 0;
   int                cur_y = 0;
   logic [LINK_W-1:0] cur_offset = '0;

   neighbor_entry_type pending_neighbors[$];
   int                 mismatches = 0;
   bit                 offering = 1'b0;
   bit                 csr_busy = 1'b0;
   bit                 holdoff_req = 1'b0;
   int                 holdoff_left = 0;
   int                 pattern_left = 0;
   int                 ready_pct = 100;
   int                 idle_cycles = 0;

   grid_neighbor_list_generator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic edge_type edge_of(input int pos, input int size);
      if (pos == 0) return EDGE_LOW;
      if (pos + 1 == size) return EDGE_HIGH;
      return EDGE_MID;
   endfunction

   function automatic void list_neighbors(input logic restart, input bit keep);
      stencil_type        st;
      edge_type           rc;
      edge_type           cc;
      int                 len;
      int                 thk;
      int                 cnt;
      int                 site;
      int                 nb;
      int                 code;
      logic [39:0]        order;
      bit                 last_site;
      neighbor_entry_type e;
      st = (cfg_mode == STENCIL_SQUARE || cfg_mode == STENCIL_CROSS) ?
           stencil_type'(cfg_mode) : STENCIL_CHAIN;
      len = (cfg_length > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : int'(cfg_length);
      thk = (cfg_thickness > DEF_MAX_THICKNESS) ? DEF_MAX_THICKNESS : int'(cfg_thickness);
      if (st == STENCIL_CHAIN) thk = 1;
      if (restart) begin
         cur_x = 0;
         cur_y = 0;
         cur_offset = '0;
      end
      if (len < 2 || (st != STENCIL_CHAIN && thk < 2)) begin
         if (keep) begin
            e = '0;
            e.dim_error = 1'b1;
            pending_neighbors.push_back(e);
         end
         return;
      end
      if (cur_x >= len || cur_y >= thk) begin
         cur_x = 0;
         cur_y = 0;
         cur_offset = '0;
      end
      rc = (st == STENCIL_CHAIN) ? EDGE_LOW : edge_of(cur_y, thk);
      cc = edge_of(cur_x, len);
      order = NEIGHBOR_ORDER[int'(st) * 9 + int'(rc) * 3 + int'(cc)];
      cnt = order[39:36];
      site = cur_x * thk + cur_y;
      last_site = (cur_x + 1 == len) && (cur_y + 1 == thk);
      for (int k = 0; k < cnt; k++) begin
         code = order[35 - 4 * k -: 4];
         nb = site + (code / 3 - 1) * thk + (code % 3 - 1);
         e.site = site[SITE_W-1:0];
         e.neighbor = nb[SITE_W-1:0];
         e.link = LINK_W'(cur_offset + k);
         e.count = COUNT_W'(cnt);
         e.last = (k + 1 == cnt);
         e.done = last_site;
         e.dim_error = 1'b0;
         if (keep) pending_neighbors.push_back(e);
      end
      if (last_site) begin
         cur_x = 0;
         cur_y = 0;
         cur_offset = '0;
      end else begin
         cur_offset = LINK_W'(cur_offset + cnt);
         cur_x++;
         if (cur_x == len) begin
            cur_x = 0;
            cur_y++;
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dimension();
      case ($urandom_range(0, 9))
         0: return CSR_DATA_W'($urandom_range(0, 1));
         1: return CSR_DATA_W'($urandom_range(257, 511));
         2: return CSR_DATA_W'(256);
         3: return CSR_DATA_W'($urandom_range(7, 255));
         default: return CSR_DATA_W'($urandom_range(2, 6));
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      csr_busy = 1'b1;
      @(posedge clock);
      case (addr)
         CSR_MODE:      cfg_mode = value[MODE_W-1:0];
         CSR_LENGTH:    cfg_length = value;
         CSR_THICKNESS: cfg_thickness = value;
         default:       ;
      endcase
   endtask

   task automatic offer_site(input logic restart, input bit typed_error);
      neighbor_entry_type e;
      if (csr_busy) begin
         csr_we <= 1'b0;
         csr_busy = 1'b0;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-1){1'b0}}, restart};
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      list_neighbors(restart, !typed_error);
      if (typed_error) begin
         e = '0;
         e.dim_error = 1'b1;
         pending_neighbors.push_back(e);
      end
   endtask

   task automatic stop_offer();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic drain();
      while (pending_neighbors.size() != 0) @(posedge clock);
   endtask

   // The response side stalls on a pattern that changes its duty now and
   // then. A hold-off request blocks it for a long stretch so that the
   // block fills up and stalls its request side.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (holdoff_req) begin
         holdoff_req = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 85;
               2: ready_pct = 50;
               default: ready_pct = 20;
            endcase
            pattern_left = $urandom_range(10, 150);
         end
         pattern_left--;
         rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   always @(posedge clock) begin
      neighbor_entry_type got;
      neighbor_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.site = rsp_tdata[15:0];
         got.neighbor = rsp_tdata[31:16];
         got.link = rsp_tdata[51:32];
         got.count = rsp_tdata[55:52];
         got.last = rsp_tlast;
         got.done = rsp_tuser[0];
         got.dim_error = rsp_tuser[1];
         if (pending_neighbors.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, got %0h", $time, got);
         end else begin
            want = pending_neighbors.pop_front();
            compare_field("site", want.site, got.site);
            compare_field("neighbor", want.neighbor, got.neighbor);
            compare_field("link_position", want.link, got.link);
            compare_field("neighbor_count", want.count, got.count);
            compare_field("last_of_site", want.last, got.last);
            compare_field("grid_done", want.done, got.done);
            compare_field("dimension_error", want.dim_error, got.dim_error);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type directed_rows [0:32];
      int           random_items;
      int           phase;
      int           n_items;
      int           burst_left;
      int           gap;
      bit           no_gaps;
      bit           broken;
      directed_rows = '{
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_LENGTH,    9'd3,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b1, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_MODE,      9'(STENCIL_SQUARE), 1'b0, 1'b0},
         '{ROW_CSR,  CSR_THICKNESS, 9'd3,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b1, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_MODE,      9'(STENCIL_CROSS), 1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_THICKNESS, 9'd2,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_LENGTH,    9'd1,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b1},
         '{ROW_CSR,  CSR_LENGTH,    9'd3,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_THICKNESS, 9'd0,   1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b1, 1'b1},
         '{ROW_CSR,  CSR_MODE,      9'd3,   1'b0, 1'b0},
         '{ROW_CSR,  CSR_LENGTH,    9'd511, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_MODE,      9'd0,   1'b0, 1'b0}
      };
      random_items = 0;
      phase = 0;
      burst_left = 1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            stop_offer();
            drain();
            write_reg(directed_rows[i].addr, directed_rows[i].value);
         end else begin
            offer_site(directed_rows[i].restart, directed_rows[i].typed_error);
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         stop_offer();
         drain();
         if (phase == 0 || $urandom_range(0, 9) < 7)
            write_reg(CSR_MODE, {7'($urandom_range(0, 127)), 2'(
                      $urandom_range(0, 3))});
         if (phase == 0 || $urandom_range(0, 9) < 7)
            write_reg(CSR_LENGTH, pick_dimension());
         if (phase == 0 || $urandom_range(0, 9) < 7)
            write_reg(CSR_THICKNESS, pick_dimension());
         broken = (cfg_length < 2) ||
                  ((cfg_mode == STENCIL_SQUARE || cfg_mode == STENCIL_CROSS) &&
                   cfg_thickness < 2);
         n_items = broken ? $urandom_range(3, 6) : $urandom_range(8, 40);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase == 1 || phase == 12) begin
            n_items = 40;
            no_gaps = 1'b1;
            holdoff_req = 1'b1;
         end
         for (int i = 0; i < n_items; i++) begin
            offer_site($urandom_range(0, 15) == 0, 1'b0);
            random_items++;
            if (!no_gaps) begin
               burst_left--;
               if (burst_left <= 0) begin
                  gap = $urandom_range(0, 8);
                  if (gap != 0) begin
                     stop_offer();
                     repeat (gap) @(posedge clock);
                  end
                  burst_left = $urandom_range(1, 12);
               end
            end
         end
         phase++;
      end

      stop_offer();
      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gnl_pkg.sv
rtl/gnl_front.sv
rtl/gnl_queue.sv
rtl/gnl_back.sv
rtl/grid_neighbor_list_generator.sv
sim/tb_grid_neighbor_list_generator.sv
